[design/y2r_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the NV12 pixel to ARGB converter.
// Has no dependencies; every other design file imports it.
package y2r_pkg;

  localparam int LUMA_W   = 8;
  localparam int CHROMA_W = 8;
  localparam int PIXEL_W  = 32;
  localparam int CFG_W    = 13;
  localparam int SUM_W    = 11;

  localparam logic [CFG_W-1:0]    ROW_WIDTH_RESET = 13'd640;
  localparam logic [CHROMA_W-1:0] CHROMA_BIAS     = 8'd128;
  localparam logic [7:0]          ALPHA_OPAQUE    = 8'hFF;
  localparam logic [7:0]          CHANNEL_MAX     = 8'd255;

  typedef logic signed [CHROMA_W-1:0] chroma_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // One pixel after chroma selection: luma plus the signed chroma pair in use.
  typedef struct packed {
    logic [LUMA_W-1:0] y;
    chroma_t           cb;
    chroma_t           cr;
  } ycc_t;

  // Saturates a signed channel sum to the 0..255 range.
  function automatic logic [7:0] clamp_byte(input sum_t v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > sum_t'({3'b000, CHANNEL_MAX})) begin
      res = CHANNEL_MAX;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

[design/y2r_in_if.sv]
`timescale 1ns / 1ps
// Input word channel: one luma byte and the chroma pair of its 2x2 site.
// Depends on y2r_pkg for field widths.
interface y2r_in_if;
  import y2r_pkg::*;

  logic                valid;
  logic                ready;
  logic [LUMA_W-1:0]   luma;
  logic [CHROMA_W-1:0] chroma_first;
  logic [CHROMA_W-1:0] chroma_second;

  modport source (output valid, output luma, output chroma_first,
                  output chroma_second, input ready);
  modport sink   (input valid, input luma, input chroma_first,
                  input chroma_second, output ready);
endinterface

[design/y2r_out_if.sv]
`timescale 1ns / 1ps
// Result word channel: one packed ARGB pixel word.
// Depends on y2r_pkg for the field width.
interface y2r_out_if;
  import y2r_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

[design/y2r_color.sv]
`timescale 1ns / 1ps
// Shift-add BT.601 color matrix with clamping and ARGB packing.
// Purely combinational; depends on y2r_pkg.
module y2r_color (
  input  y2r_pkg::ycc_t                  pix,
  output logic [y2r_pkg::PIXEL_W-1:0]    pixel_word
);
  import y2r_pkg::*;

  sum_t y_s;
  sum_t cb_s;
  sum_t cr_s;
  sum_t r_s;
  sum_t g_s;
  sum_t b_s;

  always_comb begin
    y_s  = sum_t'({3'b000, pix.y});
    cb_s = sum_t'(pix.cb);
    cr_s = sum_t'(pix.cr);
    // Arithmetic shifts round toward minus infinity, as the factors require.
    r_s = y_s + cr_s + (cr_s >>> 2) + (cr_s >>> 3) + (cr_s >>> 5);
    g_s = y_s - (cb_s >>> 2) - (cb_s >>> 4) - (cb_s >>> 5)
              - (cr_s >>> 1) - (cr_s >>> 3) - (cr_s >>> 4) - (cr_s >>> 5);
    b_s = y_s + cb_s + (cb_s >>> 1) + (cb_s >>> 2) + (cb_s >>> 6);
    pixel_word = {ALPHA_OPAQUE, clamp_byte(b_s), clamp_byte(g_s), clamp_byte(r_s)};
  end

endmodule

[design/yuv420sp_to_rgb_pixel.sv]
`timescale 1ns / 1ps
// NV12 pixel to opaque ARGB converter, one pixel word per clock while the result side is not stalled.
// An accepted word passes through two registers: the input stage, then the result register.
// The input stays ready while the result register drains.
// Reset (rst_n, synchronous, active low) clears the column counter, the held chroma pair,
// both valid flags, and sets the row width register to 640.
// Depends on y2r_pkg, y2r_in_if, y2r_out_if and y2r_color.
module yuv420sp_to_rgb_pixel #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  y2r_in_if.sink                     in_ch,
  y2r_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [y2r_pkg::CFG_W-1:0]  cfg_wdata
);
  import y2r_pkg::*;

  // Column counter width, and a compare width wide enough for both the
  // register value and the largest allowed row width.
  localparam int CW     = $clog2(MAX_ROW_WIDTH);
  localparam int MAX_LW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int WW     = (CFG_W > MAX_LW) ? CFG_W : MAX_LW;

  logic [CFG_W-1:0]    rw_r;
  logic [CW-1:0]       col_r;
  chroma_t             held_cb_r;
  chroma_t             held_cr_r;
  logic                s1_v_r;
  ycc_t                s1_r;
  logic                out_v_r;
  logic [PIXEL_W-1:0]  out_word_r;

  logic [WW-1:0]       rw_ext;
  logic [WW-1:0]       eff_w;
  logic [CW-1:0]       col_cur;
  logic [WW-1:0]       col_inc;
  logic [CW-1:0]       col_nxt;
  logic                even_col;
  chroma_t             cb_in;
  chroma_t             cr_in;
  ycc_t                s1_nxt;
  logic                out_adv;
  logic                s1_adv;
  logic                in_acc;
  logic [PIXEL_W-1:0]  color_word;

  // The row width register is taken as 1 when zero and saturated to the
  // largest supported width when above it.
  always_comb begin
    rw_ext = WW'(rw_r);
    if (rw_r == '0) begin
      eff_w = WW'(1);
    end else if (rw_ext > WW'(MAX_ROW_WIDTH)) begin
      eff_w = WW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
  end

  // A counter left beyond a narrowed row width restarts the row. The chroma
  // pair is sampled on even columns and reused on the odd column after it.
  always_comb begin
    col_cur  = (WW'(col_r) >= eff_w) ? '0 : col_r;
    col_inc  = WW'(col_cur) + WW'(1);
    col_nxt  = (col_inc >= eff_w) ? '0 : col_inc[CW-1:0];
    even_col = ~col_cur[0];
    cb_in    = chroma_t'(in_ch.chroma_first - CHROMA_BIAS);
    cr_in    = chroma_t'(in_ch.chroma_second - CHROMA_BIAS);
    s1_nxt.y  = in_ch.luma;
    s1_nxt.cb = even_col ? cb_in : held_cb_r;
    s1_nxt.cr = even_col ? cr_in : held_cr_r;
  end

  // Ready ripples back through the two stages, so a full pipe still takes a
  // new word in any cycle in which the result is taken.
  assign out_adv     = !out_v_r || out_ch.ready;
  assign s1_adv      = !s1_v_r || out_adv;
  assign in_ch.ready = s1_adv;
  assign in_acc      = in_ch.valid && s1_adv;

  y2r_color u_color (
    .pix        (s1_r),
    .pixel_word (color_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_r      <= ROW_WIDTH_RESET;
      col_r     <= '0;
      held_cb_r <= '0;
      held_cr_r <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rw_r <= cfg_wdata;
      end
      if (in_acc) begin
        col_r     <= col_nxt;
        held_cb_r <= s1_nxt.cb;
        held_cr_r <= s1_nxt.cr;
      end
      if (s1_adv) begin
        s1_v_r <= in_acc;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (out_adv && s1_v_r) begin
      out_word_r <= color_word;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.pixel_word = out_word_r;

`ifndef SYNTHESIS
  // An accepted word always lands in the input stage.
  a_accept_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted word did not enter the input stage");

  // Odd columns reuse the chroma pair held from the even column before them.
  a_odd_reuses_chroma : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_cur[0]) |=>
      (s1_r.cb == $past(held_cb_r) && s1_r.cr == $past(held_cr_r)))
    else $error("odd column did not reuse the held chroma pair");

  // With both stages full and the result stalled, no new word may enter.
  a_full_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while the pipeline is full and stalled");

  // Every delivered pixel is opaque.
  a_alpha_opaque : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_word_r[PIXEL_W-1:PIXEL_W-8] == ALPHA_OPAQUE))
    else $error("result word is not opaque");
`endif

endmodule

[tb/y2r_pixel_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the NV12 pixel converter: watches both word channels and the
// row width port, predicts every ARGB word and compares it with the block's.
// Depends on y2r_pkg, y2r_in_if and y2r_out_if.
module y2r_pixel_checker #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  y2r_in_if                         in_ch,
  y2r_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [y2r_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatch_count,
  output int                        pending_words,
  output int                        words_checked
);
  import y2r_pkg::*;

  logic [CFG_W-1:0]   row_width_q;
  int                 column_q;
  int                 cb_q;
  int                 cr_q;
  logic [PIXEL_W-1:0] expected_pixels[$];

  function automatic logic [7:0] saturate_channel(input int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // A width of zero behaves as one; anything above the maximum saturates.
  function automatic int active_width(input logic [CFG_W-1:0] w);
    int n;
    n = int'(w);
    if (n == 0) n = 1;
    if (n > MAX_ROW_WIDTH) n = MAX_ROW_WIDTH;
    return n;
  endfunction

  // All operands are int, so >>> is a floor shift on negative chroma.
  function automatic logic [PIXEL_W-1:0] argb_word(input int y, input int cb, input int cr);
    int r;
    int g;
    int b;
    r = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
    g = y - (cb >>> 2) - (cb >>> 4) - (cb >>> 5)
          - (cr >>> 1) - (cr >>> 3) - (cr >>> 4) - (cr >>> 5);
    b = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
    return {ALPHA_OPAQUE, saturate_channel(b), saturate_channel(g), saturate_channel(r)};
  endfunction

  always @(posedge clk) begin : monitor
    int                 w;
    int                 y;
    logic [PIXEL_W-1:0] want;
    if (!rst_n) begin
      row_width_q    = ROW_WIDTH_RESET;
      column_q       = 0;
      cb_q           = 0;
      cr_q           = 0;
      mismatch_count = 0;
      words_checked  = 0;
      expected_pixels.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: pixel word expected none, got %08h", $time, out_ch.pixel_word);
        end else begin
          want = expected_pixels.pop_front();
          words_checked++;
          if (out_ch.pixel_word !== want) begin
            mismatch_count++;
            $display("%0t ns: pixel word expected %08h, got %08h",
                     $time, want, out_ch.pixel_word);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w = active_width(row_width_q);
        if (column_q >= w) column_q = 0;
        if (column_q % 2 == 0) begin
          cb_q = int'(in_ch.chroma_first) - int'(CHROMA_BIAS);
          cr_q = int'(in_ch.chroma_second) - int'(CHROMA_BIAS);
        end
        y = int'(in_ch.luma);
        expected_pixels.push_back(argb_word(y, cb_q, cr_q));
        column_q++;
        if (column_q >= w) column_q = 0;
      end
      if (cfg_we) begin
        row_width_q = cfg_wdata;
      end
    end
    pending_words = expected_pixels.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the NV12 pixel converter bench: clock, reset, stimulus and verdict.
// Depends on y2r_pkg, y2r_in_if, y2r_out_if, the converter and y2r_pixel_checker.
module testbench;
  import y2r_pkg::*;

  localparam int MAX_W           = 4096;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 16;
  // Far above the slowest correct run, which needs a few tens of microseconds.
  localparam int RUN_LIMIT_NS    = 2_000_000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Percent of cycles in which each side idles; the hold-off request asks the
  // result side to stall for a long counted stretch.
  int in_idle_pct  = 31;
  int out_idle_pct = 31;
  bit hold_off_req = 1'b0;

  int words_sent;
  int widths_written;
  int mismatch_count;
  int pending_words;
  int words_checked;

  y2r_in_if  in_ch();
  y2r_out_if out_ch();

  yuv420sp_to_rgb_pixel #(
    .MAX_ROW_WIDTH(MAX_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  y2r_pixel_checker #(
    .MAX_ROW_WIDTH(MAX_W)
  ) pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side backpressure. Ready changes only at the falling edge. A hold-off
  // request keeps ready low for a long stretch counted here, which lets the
  // block fill up and stall its input while the sender keeps going.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Hard stop in case the block hangs or drops words.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d pixel words outstanding", pending_words);
    $display("Mismatches found");
    $finish;
  end

  // Offers one pixel word and returns right after the edge that accepts it.
  // Valid is left high, so a back-to-back call keeps the channel busy without
  // dropping valid; random idle cycles come first and carry junk payload.
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] cf, input logic [7:0] cs);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid         <= 1'b0;
      in_ch.luma          <= 8'($urandom);
      in_ch.chroma_first  <= 8'($urandom);
      in_ch.chroma_second <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.luma          <= y;
    in_ch.chroma_first  <= cf;
    in_ch.chroma_second <= cs;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // Drops valid after the last accepted word so it is not taken twice.
  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // The row width is only changed once every word in flight has come out.
  task automatic write_row_width(input logic [CFG_W-1:0] w);
    wait (pending_words == 0);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    widths_written++;
  endtask

  // Mostly uniform bytes, with the range ends and the chroma midpoint mixed in.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = 8'h7F;
        default: v = 8'h80;
      endcase
    end
    return v;
  endfunction

  initial begin : stimulus
    int width;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.luma          = '0;
    in_ch.chroma_first  = '0;
    in_ch.chroma_second = '0;
    words_sent          = 0;
    widths_written      = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset width of 640. Neutral chroma first, then the chroma extremes that
    // drive red and blue into both clamps and green the other way. Odd columns
    // carry chroma that must be ignored in favor of the pair held from the
    // even column before.
    send_pixel(8'h00, 8'h80, 8'h80);
    send_pixel(8'hFF, 8'h80, 8'h80);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h80, 8'hFF, 8'h00);
    send_pixel(8'h80, 8'h00, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    stop_sending();

    // A zero width acts as a width of one, so every word latches its own chroma.
    write_row_width('0);
    send_pixel(8'h0A, 8'hC8, 8'h3C);
    send_pixel(8'hF0, 8'h1E, 8'hDC);
    send_pixel(8'h80, 8'h7F, 8'h81);
    send_pixel(8'h4D, 8'h81, 8'h7F);
    stop_sending();

    // The widest value on the port saturates to the maximum row width.
    write_row_width({CFG_W{1'b1}});
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'h02, 8'h03);
    stop_sending();

    // Three words into a wide row the width drops to two, so the column is past
    // the new end and the next word starts a fresh row on an even column.
    write_row_width(CFG_W'(2));
    send_pixel(8'h30, 8'hE0, 8'h20);
    send_pixel(8'hC0, 8'h10, 8'hF0);
    send_pixel(8'h60, 8'h90, 8'h70);
    stop_sending();
    write_row_width(CFG_W'(MAX_W));
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'h9A, 8'hBC, 8'hDE);

    // Random phases. Most widths are short so rows wrap often; each phase starts
    // at whatever column the last one left, which also changes widths mid-row.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      stop_sending();
      case (p)
        0: width = 1;
        1: width = 2;
        2: width = 3;
        3: width = $urandom_range(4, 16);
        4: width = MAX_W;
        5: width = $urandom_range(0, (1 << CFG_W) - 1);
        6: width = $urandom_range(5, 40);
        default: width = $urandom_range(1, 8);
      endcase
      write_row_width(CFG_W'(width));
      in_idle_pct  = 31;
      out_idle_pct = 31;
      // One whole phase runs at full rate on both sides.
      if (p == 2) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Long result stall while the sender keeps offering words at full rate.
        if (p == 3 && i == 50) begin
          hold_off_req = 1'b1;
          in_idle_pct  = 0;
        end
        if (p == 3 && i == 150) begin
          in_idle_pct = 31;
        end
        // The sender goes quiet until every word in flight has been checked.
        if (p == 5 && i == 120) begin
          stop_sending();
          wait (pending_words == 0);
        end
        send_pixel(pick_byte(), pick_byte(), pick_byte());
      end
    end
    stop_sending();

    wait (pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixel words (%0d compared) under %0d row width settings,",
             words_sent, words_checked, widths_written);
    $display("covering zero, saturated and mid-row width changes, stalls and full-rate runs.");
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
